// ===== rtl/mrpt_pkg.sv =====
// Shared types and constants for the Miller-Rabin prime test block.
package mrpt_pkg;

    // Controller state codes
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SMALL = 4'd1;
    localparam logic [3:0] S_RED   = 4'd2;
    localparam logic [3:0] S_STRIP = 4'd3;
    localparam logic [3:0] S_PCHK  = 4'd4;
    localparam logic [3:0] S_PMXW  = 4'd5;
    localparam logic [3:0] S_PSQS  = 4'd6;
    localparam logic [3:0] S_PSQW  = 4'd7;
    localparam logic [3:0] S_CHECK = 4'd8;
    localparam logic [3:0] S_LOOP  = 4'd9;
    localparam logic [3:0] S_LW    = 4'd10;
    localparam logic [3:0] S_LCHK  = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;

    // Modular multiply operand selection
    localparam logic [1:0] MSEL_X_BASE = 2'd0;
    localparam logic [1:0] MSEL_BASE_SQ = 2'd1;
    localparam logic [1:0] MSEL_X_SQ = 2'd2;

    typedef struct packed {
        logic       load;
        logic       red_step;
        logic       strip_step;
        logic       mul_start;
        logic [1:0] mul_sel;
        logic       mul_wb;
        logic       d_shift;
        logic       s_dec;
    } t_cmd;

    typedef struct packed {
        logic small_n;
        logic small_pass;
        logic red_done;
        logic d_odd;
        logic d_zero;
        logic d_lsb;
        logic mul_done;
        logic x_one;
        logic x_nm1;
        logic s_le1;
    } t_sts;

endpackage

// ===== rtl/mrpt_datapath.sv =====
// Datapath: operand registers, modulo reduction, exponent strip and multiply-reduce unit.
module mrpt_datapath #(
    parameter int NUM_WIDTH = 32
) (
    input  logic           i_clk,
    input  logic [31:0]    i_candidate,
    input  logic [31:0]    i_witness,
    input  mrpt_pkg::t_cmd i_cmd,
    output mrpt_pkg::t_sts o_sts
);
    import mrpt_pkg::*;

    localparam int W  = NUM_WIDTH;
    localparam int IW = (NUM_WIDTH < 32) ? NUM_WIDTH : 32;
    localparam int CW = $clog2(NUM_WIDTH + 1);

    logic [W-1:0]  r_n, r_nm1, r_d, r_w, r_rem, r_x;
    logic [W-1:0]  r_ma, r_mb, r_macc;
    logic [1:0]    r_msel;
    logic [CW-1:0] r_cnt, r_s;

    logic [W-1:0] cand_m, wit_m;
    logic [W:0]   red_t;
    logic [W-1:0] red_next;
    logic [W-1:0] op_a, op_b;
    logic [W-1:0] acc_next, a_next;

    // (a + b) mod m with a, b below m
    function automatic logic [W-1:0] add_mod(input logic [W-1:0] a, input logic [W-1:0] b,
                                             input logic [W-1:0] m);
        logic [W-1:0] room;
        room = m - b;
        add_mod = (a >= room) ? (a - room) : (a + b);
    endfunction

    assign cand_m = W'(i_candidate[IW-1:0]);
    assign wit_m  = W'(i_witness[IW-1:0]);

    // One restoring-division bit of witness mod n
    assign red_t    = {r_rem, r_w[W-1]};
    assign red_next = (red_t >= {1'b0, r_n}) ? W'(red_t - {1'b0, r_n}) : red_t[W-1:0];

    // Pick multiply operands; base lives in r_rem
    always_comb begin
        case (i_cmd.mul_sel)
            MSEL_X_BASE: begin
                op_a = r_x;
                op_b = r_rem;
            end
            MSEL_BASE_SQ: begin
                op_a = r_rem;
                op_b = r_rem;
            end
            MSEL_X_SQ: begin
                op_a = r_x;
                op_b = r_x;
            end
            default: begin
                op_a = r_x;
                op_b = r_x;
            end
        endcase
    end

    assign acc_next = r_mb[0] ? add_mod(r_macc, r_ma, r_n) : r_macc;
    assign a_next   = add_mod(r_ma, r_ma, r_n);

    // Operand and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n   <= cand_m;
            r_nm1 <= cand_m - W'(1);
            r_d   <= cand_m - W'(1);
            r_w   <= wit_m;
            r_rem <= '0;
            r_x   <= W'(1);
            r_s   <= '0;
            r_cnt <= CW'(W);
        end else begin
            if (i_cmd.red_step) begin
                r_rem <= red_next;
                r_w   <= {r_w[W-2:0], 1'b0};
                r_cnt <= r_cnt - CW'(1);
            end
            if (i_cmd.strip_step) begin
                r_d <= {1'b0, r_d[W-1:1]};
                r_s <= r_s + CW'(1);
            end
            if (i_cmd.d_shift) begin
                r_d <= {1'b0, r_d[W-1:1]};
            end
            if (i_cmd.s_dec) begin
                r_s <= r_s - CW'(1);
            end
            if (i_cmd.mul_wb) begin
                if (r_msel == MSEL_BASE_SQ) begin
                    r_rem <= r_macc;
                end else begin
                    r_x <= r_macc;
                end
            end
        end
    end

    // Shift-and-add multiply-reduce unit, one multiplier bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start) begin
            r_ma   <= op_a;
            r_mb   <= op_b;
            r_macc <= '0;
            r_msel <= i_cmd.mul_sel;
        end else if (r_mb != '0) begin
            r_macc <= acc_next;
            r_ma   <= a_next;
            r_mb   <= {1'b0, r_mb[W-1:1]};
        end
    end

    assign o_sts.small_n    = (r_n == W'(0)) || (r_n == W'(1)) || (r_n == W'(2)) ||
                              (r_n == W'(3)) || (r_n == W'(4));
    assign o_sts.small_pass = (r_n == W'(2)) || (r_n == W'(3));
    assign o_sts.red_done   = (r_cnt == '0);
    assign o_sts.d_odd      = r_d[0];
    assign o_sts.d_zero     = (r_d == '0);
    assign o_sts.d_lsb      = r_d[0];
    assign o_sts.mul_done   = (r_mb == '0);
    assign o_sts.x_one      = (r_x == W'(1));
    assign o_sts.x_nm1      = (r_x == r_nm1);
    assign o_sts.s_le1      = (r_s <= CW'(1));

endmodule

// ===== rtl/mrpt_ctrl.sv =====
// Controller: round sequencing, group pass flag and verdict output register.
module mrpt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic           i_last_witness,
    output logic           o_valid,
    input  logic           i_ready,
    output logic           o_is_probable_prime,
    output mrpt_pkg::t_cmd o_cmd,
    input  mrpt_pkg::t_sts i_sts
);
    import mrpt_pkg::*;

    logic [3:0] r_state, n_state;
    logic       r_last, r_res, n_res, r_pass, n_pass;
    logic       r_ovalid, n_ovalid, r_odata, n_odata;

    assign o_ready             = (r_state == S_IDLE);
    assign o_valid             = r_ovalid;
    assign o_is_probable_prime = r_odata;

    // Next state and command decode
    always_comb begin
        n_state  = r_state;
        n_res    = r_res;
        n_pass   = r_pass;
        n_ovalid = r_ovalid && !i_ready;
        n_odata  = r_odata;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SMALL;
                end
            end
            S_SMALL: begin
                if (i_sts.small_n) begin
                    n_res   = i_sts.small_pass;
                    n_state = S_DONE;
                end else begin
                    n_state = S_RED;
                end
            end
            S_RED: begin
                if (i_sts.red_done) begin
                    n_state = S_STRIP;
                end else begin
                    o_cmd.red_step = 1'b1;
                end
            end
            S_STRIP: begin
                if (i_sts.d_odd) begin
                    n_state = S_PCHK;
                end else begin
                    o_cmd.strip_step = 1'b1;
                end
            end
            S_PCHK: begin
                if (i_sts.d_zero) begin
                    n_state = S_CHECK;
                end else if (i_sts.d_lsb) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = MSEL_X_BASE;
                    n_state         = S_PMXW;
                end else begin
                    n_state = S_PSQS;
                end
            end
            S_PMXW: begin
                if (i_sts.mul_done) begin
                    o_cmd.mul_wb = 1'b1;
                    n_state      = S_PSQS;
                end
            end
            S_PSQS: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MSEL_BASE_SQ;
                n_state         = S_PSQW;
            end
            S_PSQW: begin
                o_cmd.mul_sel = MSEL_BASE_SQ;
                if (i_sts.mul_done) begin
                    o_cmd.mul_wb  = 1'b1;
                    o_cmd.d_shift = 1'b1;
                    n_state       = S_PCHK;
                end
            end
            S_CHECK: begin
                if (i_sts.x_one || i_sts.x_nm1) begin
                    n_res   = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_LOOP;
                end
            end
            S_LOOP: begin
                if (i_sts.s_le1) begin
                    n_res   = 1'b0;
                    n_state = S_DONE;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = MSEL_X_SQ;
                    o_cmd.s_dec     = 1'b1;
                    n_state         = S_LW;
                end
            end
            S_LW: begin
                o_cmd.mul_sel = MSEL_X_SQ;
                if (i_sts.mul_done) begin
                    o_cmd.mul_wb = 1'b1;
                    n_state      = S_LCHK;
                end
            end
            S_LCHK: begin
                if (i_sts.x_nm1) begin
                    n_res   = 1'b1;
                    n_state = S_DONE;
                end else if (i_sts.x_one) begin
                    n_res   = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_state = S_LOOP;
                end
            end
            S_DONE: begin
                // fold round into group flag; emit verdict on the last item
                if (!r_last) begin
                    n_pass  = r_pass && r_res;
                    n_state = S_IDLE;
                end else if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_odata  = r_pass && r_res;
                    n_pass   = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pass   <= 1'b1;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pass   <= n_pass;
            r_ovalid <= n_ovalid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_res   <= n_res;
        r_odata <= n_odata;
        if (o_cmd.load) begin
            r_last <= i_last_witness;
        end
    end

endmodule

// ===== rtl/miller_rabin_prime_test_top.sv =====
// Miller-Rabin prime test: one witness round per item, verdict on the last witness of a group.
// One item is processed at a time. A round reduces the witness modulo the candidate by
// restoring division over its NUM_WIDTH bits, strips the trailing zeros of n-1 to get d and
// s, then runs square-and-multiply over the bits of d with a shared shift-and-add
// multiply-reduce unit, and up to s-1 further squarings. Candidates 0 to 4 are decided
// directly, without reduction or multiplication.
// A verdict waits in an output register; the next group keeps running behind it.
module miller_rabin_prime_test_top #(
    parameter int NUM_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_candidate,
    input  logic [31:0] i_witness,
    input  logic        i_last_witness,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_is_probable_prime
);
    import mrpt_pkg::*;

    t_cmd cmd;
    t_sts sts;

    mrpt_ctrl u_ctrl (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_last_witness      (i_last_witness),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_is_probable_prime (o_is_probable_prime),
        .o_cmd               (cmd),
        .i_sts               (sts)
    );

    mrpt_datapath #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_candidate (i_candidate),
        .i_witness   (i_witness),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

// ===== tb/sv/tb_miller_rabin_prime_test_top.sv =====
// Self-checking testbench for the Miller-Rabin prime test block.
module tb_miller_rabin_prime_test_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NW = 32;
    localparam int STALL_LIMIT = 40000;
    localparam int N_RANDOM = 220;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_candidate;
    logic [31:0] i_witness;
    logic        i_last_witness;
    logic        o_valid;
    logic        i_ready;
    logic        o_is_probable_prime;

    miller_rabin_prime_test_top #(.NUM_WIDTH(NW)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_candidate(i_candidate), .i_witness(i_witness),
        .i_last_witness(i_last_witness), .o_valid(o_valid), .i_ready(i_ready),
        .o_is_probable_prime(o_is_probable_prime)
    );

    // Directed item with an optional hand-typed verdict (2 = use the predictor)
    typedef struct {
        logic [31:0] cand;
        logic [31:0] wit;
        logic        last;
        logic [1:0]  verdict;
    } t_row;

    t_row        rows[$];
    logic        verdict_q[$];
    logic        group_ok;
    int          errors;
    int          verdicts_seen;
    int          items_sent;
    int          idle_cnt;
    logic        quiet;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // Modular arithmetic at double width
    function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
        logic [127:0] p;
        p = a * b;
        return 64'(p % m);
    endfunction

    function automatic logic round_passes(logic [63:0] n, logic [63:0] w);
        logic [63:0] nm1, d, x, base, e;
        int s;
        if (n == 0 || n == 1 || n == 4) return 1'b0;
        if (n == 2 || n == 3) return 1'b1;
        nm1 = n - 1;
        d = nm1;
        s = 0;
        while (d[0] == 1'b0) begin
            d = d >> 1;
            s++;
        end
        x = 1;
        base = w % n;
        e = d;
        while (e != 0) begin
            if (e[0]) x = mulmod(x, base, n);
            base = mulmod(base, base, n);
            e = e >> 1;
        end
        if (x == 1 || x == nm1) return 1'b1;
        for (int i = 1; i < s; i++) begin
            x = mulmod(x, x, n);
            if (x == nm1) return 1'b1;
            if (x == 1) return 1'b0;
        end
        return 1'b0;
    endfunction

    // Fold one accepted item into the group flag; queue a verdict on the last witness
    function automatic void predict_item(logic [31:0] c, logic [31:0] w, logic last,
                                         logic [1:0] typed);
        group_ok = group_ok & round_passes(64'(c), 64'(w));
        if (last) begin
            if (typed != 2 && typed[0] != group_ok) begin
                $display("%0t typed verdict %0d disagrees with predictor %0d",
                         $time, typed[0], group_ok);
                errors++;
            end
            verdict_q.push_back(group_ok);
            group_ok = 1'b1;
        end
    endfunction

    // Check each accepted verdict against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            verdicts_seen++;
            if (verdict_q.size() == 0) begin
                $display("%0t unexpected verdict: expected none, actual %0d",
                         $time, o_is_probable_prime);
                errors++;
            end else begin
                if (o_is_probable_prime !== verdict_q[0]) begin
                    $display("%0t is_probable_prime mismatch: expected %0d, actual %0d",
                             $time, verdict_q[0], o_is_probable_prime);
                    errors++;
                end
                void'(verdict_q.pop_front());
            end
        end
    end

    // Receiver stalls in random bursts
    always @(posedge i_clk) begin
        int burst;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            burst = 0;
        end else if (quiet) begin
            i_ready <= 1'b1;
        end else if (burst > 0) begin
            burst--;
            i_ready <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            burst = $urandom_range(0, 4);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Watchdog on cycles without any accepted item or verdict
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Send one item and hold it until accepted; sometimes idle with noise on the payload first
    task automatic send_item(logic [31:0] c, logic [31:0] w, logic last, logic [1:0] typed);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid        <= 1'b0;
            i_candidate    <= $urandom;
            i_witness      <= $urandom;
            i_last_witness <= 1'($urandom_range(0, 1));
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_candidate    <= c;
        i_witness      <= w;
        i_last_witness <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_item(c, w, last, typed);
        items_sent++;
    endtask

    function automatic logic [31:0] rand_cand();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 12);
            1: return $urandom_range(5, 1000) | 32'd1;
            2: return $urandom | 32'h8000_0001;
            3: return $urandom;
            default: return ($urandom_range(3, 65535) | 32'd1);
        endcase
    endfunction

    initial begin
        int pick;
        logic [31:0] c;
        int group_len;
        errors = 0; verdicts_seen = 0; items_sent = 0; idle_cnt = 0;
        group_ok = 1'b1;
        quiet = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_candidate = '0;
        i_witness = '0;
        i_last_witness = 1'b0;

        // Small candidates, extremes, even candidates, witness a multiple of n
        rows.push_back('{32'd0, 32'd5, 1'b1, 2'd0});
        rows.push_back('{32'd1, 32'd7, 1'b1, 2'd0});
        rows.push_back('{32'd2, 32'hFFFF_FFFF, 1'b1, 2'd1});
        rows.push_back('{32'd3, 32'd0, 1'b1, 2'd1});
        rows.push_back('{32'd4, 32'd3, 1'b1, 2'd0});
        rows.push_back('{32'd7, 32'd14, 1'b1, 2'd0});
        rows.push_back('{32'd13, 32'd2, 1'b1, 2'd2});
        rows.push_back('{32'd561, 32'd2, 1'b0, 2'd2});
        rows.push_back('{32'd561, 32'd5, 1'b0, 2'd2});
        rows.push_back('{32'd561, 32'd7, 1'b1, 2'd2});
        rows.push_back('{32'hFFFF_FFFB, 32'd2, 1'b0, 2'd2});
        rows.push_back('{32'hFFFF_FFFB, 32'hFFFF_FFFF, 1'b1, 2'd2});
        rows.push_back('{32'hFFFF_FFFF, 32'd3, 1'b1, 2'd2});
        rows.push_back('{32'hFFFF_FFFE, 32'd3, 1'b1, 2'd2});
        rows.push_back('{32'd341, 32'd2, 1'b1, 2'd2});
        rows.push_back('{32'd2, 32'd1, 1'b0, 2'd2});
        rows.push_back('{32'd0, 32'd1, 1'b0, 2'd2});
        rows.push_back('{32'd97, 32'd96, 1'b1, 2'd2});
        rows.push_back('{32'h7FFF_FFFF, 32'h5555_AAAA, 1'b1, 2'd2});
        rows.push_back('{32'd5, 32'd1, 1'b1, 2'd1});

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) send_item(rows[k].cand, rows[k].wit, rows[k].last, rows[k].verdict);

        // Random groups of witnesses over one candidate, with some noise items
        while (items_sent < rows.size() + N_RANDOM) begin
            if (items_sent > rows.size() + N_RANDOM - 30) quiet = 1'b1;
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                send_item($urandom, $urandom, 1'($urandom_range(0, 1)), 2'd2);
            end else begin
                c = rand_cand();
                group_len = $urandom_range(1, 4);
                for (int j = 0; j < group_len; j++)
                    send_item(c, ($urandom_range(0, 7) == 0) ? c * $urandom_range(0, 3)
                                                              : $urandom,
                              j == group_len - 1, 2'd2);
            end
        end
        i_valid <= 1'b0;

        // Drain the remaining verdicts
        quiet = 1'b1;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("Sent %0d items, checked %0d verdicts over small, even, prime and",
                 items_sent, verdicts_seen);
        $display("composite candidates with random witness groups and stalls.");
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// ===== miller_rabin_prime_test_top.f =====
rtl/mrpt_pkg.sv
rtl/mrpt_datapath.sv
rtl/mrpt_ctrl.sv
rtl/miller_rabin_prime_test_top.sv
tb/sv/tb_miller_rabin_prime_test_top.sv
